// File: hdl/afm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the mono DAC feeder.
// No dependencies.
package afm_pkg;

  localparam int FIFO_DEPTH = 1024;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = (PTR_W > 10) ? PTR_W : 10;

  localparam int SAMPLE_W   = 16;
  localparam int PERIOD_W   = 20;
  localparam int CODE_W     = 10;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1359);
  localparam logic [CODE_W-1:0]   DAC_ZERO     = CODE_W'(512);

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_TICK = 2'd1,
    FUNC_STOP = 2'd2
  } func_e;

  // front stage output, one per beat taken
  typedef struct packed {
    logic              valid;
    logic              accepted;
    logic              dac_valid;
    logic              underflow;
    logic              from_mem;
    logic [CODE_W-1:0] fifo_count;
    logic              render_on;
  } stg_t;

  typedef struct packed {
    logic              accepted;
    logic              dac_valid;
    logic [CODE_W-1:0] dac_code;
    logic              underflow;
    logic [CODE_W-1:0] fifo_count;
    logic              render_on;
  } res_t;

  // offset binary: top bits of (s + 0x8000)
  function automatic logic [CODE_W-1:0] to_dac(input logic [SAMPLE_W-1:0] s);
    return {~s[SAMPLE_W-1], s[SAMPLE_W-2:SAMPLE_W-CODE_W]};
  endfunction

endpackage

// File: hdl/afm_front.sv
`timescale 1ns / 1ps
// Front end: sample store, pointers, rate timer and render flag.
// Depends on afm_pkg.
module afm_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [afm_pkg::PERIOD_W-1:0]     cfg_wdata_i,
  input  logic                             beat_i,
  input  logic [1:0]                       func_i,
  input  logic signed [afm_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [afm_pkg::SAMPLE_W-1:0] right_sample_i,
  input  logic                             mix_two_i,
  input  logic                             block_end_i,
  output afm_pkg::stg_t                    stg_o,
  output logic [afm_pkg::SAMPLE_W-1:0]     rd_data_o
);
  import afm_pkg::*;

  logic [SAMPLE_W-1:0] sample_mem_q [FIFO_DEPTH];
  logic [SAMPLE_W-1:0] sample_rd_q;

  logic [PTR_W-1:0]    wp_q, wp_d, rp_q, rp_d, wp_inc, rp_inc;
  logic [PERIOD_W-1:0] tick_q, tick_d, period_q;
  logic                render_q, render_d;
  stg_t                stg_q, stg_d;

  logic                not_full, not_empty, wr_en, rd_en;
  logic [SAMPLE_W:0]   mix_sum;
  logic [SAMPLE_W-1:0] wr_data;
  logic [CNT_W:0]      held;

  assign wp_inc    = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_inc    = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign not_full  = (wp_inc != rp_q);
  assign not_empty = (wp_q != rp_q);
  assign mix_sum   = {left_sample_i[SAMPLE_W-1], left_sample_i}
                   + {right_sample_i[SAMPLE_W-1], right_sample_i};
  assign wr_data   = mix_two_i ? mix_sum[SAMPLE_W:1] : left_sample_i;

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    tick_d   = tick_q;
    render_d = render_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    stg_d    = '0;
    stg_d.valid = beat_i;
    if (beat_i) begin
      case (func_i)
        FUNC_PUSH: begin
          if (not_full) begin
            wr_en          = 1'b1;
            wp_d           = wp_inc;
            stg_d.accepted = 1'b1;
            if (block_end_i) begin
              render_d = 1'b1;
            end
          end
        end
        FUNC_TICK: begin
          if (render_q) begin
            if (tick_q >= period_q) begin
              tick_d          = '0;
              stg_d.dac_valid = 1'b1;
              if (not_empty) begin
                rd_en          = 1'b1;
                rp_d           = rp_inc;
                stg_d.from_mem = 1'b1;
              end else begin
                stg_d.underflow = 1'b1;
              end
            end else begin
              tick_d = tick_q + 1'b1;
            end
          end
        end
        FUNC_STOP: begin
          render_d = 1'b0;
        end
        default: begin
        end
      endcase
    end
    if (wp_d >= rp_d) begin
      held = (CNT_W+1)'(wp_d) - (CNT_W+1)'(rp_d);
    end else begin
      held = (CNT_W+1)'(wp_d) + (CNT_W+1)'(FIFO_DEPTH) - (CNT_W+1)'(rp_d);
    end
    stg_d.fifo_count = held[CODE_W-1:0];
    stg_d.render_on  = render_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sample_mem_q[wp_q] <= wr_data;
    end
    if (rd_en) begin
      sample_rd_q <= sample_mem_q[rp_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      tick_q   <= '0;
      render_q <= 1'b0;
      period_q <= PERIOD_RESET;
      stg_q    <= '0;
    end else begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      tick_q   <= tick_d;
      render_q <= render_d;
      stg_q    <= stg_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
    end
  end

  assign stg_o     = stg_q;
  assign rd_data_o = sample_rd_q;

endmodule

// File: hdl/afm_resq.sv
`timescale 1ns / 1ps
// Back end: short result queue between the front stage and the consumer.
// Depends on afm_pkg.
module afm_resq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  afm_pkg::res_t                 data_i,
  input  logic                          pop_i,
  output afm_pkg::res_t                 head_o,
  output logic                          empty_o,
  output logic [afm_pkg::RQ_CNT_W-1:0]  count_o
);
  import afm_pkg::*;

  res_t                entry_q [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_q, rd_q;
  logic [RQ_CNT_W-1:0] cnt_q;
  logic                do_pop;

  assign empty_o = (cnt_q == '0);
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + RQ_CNT_W'(push_i) - RQ_CNT_W'(do_pop);
    end
  end

endmodule

// File: hdl/audio_fifo_mono_dac_feeder.sv
`timescale 1ns / 1ps
// Mono PCM sample FIFO with DAC rate timer. Depends on afm_pkg, afm_front, afm_resq.
// Beats pass the front stage register into the result queue, whose head drives the outputs.
// Throughput: one beat per cycle while not full; the store has one write and one read port.
// full rises while the four-entry result queue and the front stage hold four beats.
// Reset (async, low): pointers, timer and render flag cleared, period 1359; store untouched.
module audio_fifo_mono_dac_feeder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [afm_pkg::PERIOD_W-1:0]       cfg_wdata_i,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         func_i,
  input  logic signed [afm_pkg::SAMPLE_W-1:0] left_sample_i,
  input  logic signed [afm_pkg::SAMPLE_W-1:0] right_sample_i,
  input  logic                               mix_two_i,
  input  logic                               block_end_i,
  output logic                               empty,
  input  logic                               pop,
  output logic                               accepted_o,
  output logic                               dac_valid_o,
  output logic [afm_pkg::CODE_W-1:0]         dac_code_o,
  output logic                               underflow_o,
  output logic [afm_pkg::CODE_W-1:0]         fifo_count_o,
  output logic                               render_on_o
);
  import afm_pkg::*;

  stg_t                stg;
  res_t                res_in, res_out;
  logic [SAMPLE_W-1:0] rd_data;
  logic [RQ_CNT_W-1:0] q_count;
  logic                beat;

  assign full = ((RQ_CNT_W+1)'(q_count) + (RQ_CNT_W+1)'(stg.valid))
              >= (RQ_CNT_W+1)'(RQ_DEPTH);
  assign beat = push && !full;

  afm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .beat_i         (beat),
    .func_i         (func_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .mix_two_i      (mix_two_i),
    .block_end_i    (block_end_i),
    .stg_o          (stg),
    .rd_data_o      (rd_data)
  );

  always_comb begin
    res_in.accepted   = stg.accepted;
    res_in.dac_valid  = stg.dac_valid;
    res_in.underflow  = stg.underflow;
    res_in.fifo_count = stg.fifo_count;
    res_in.render_on  = stg.render_on;
    if (!stg.dac_valid) begin
      res_in.dac_code = '0;
    end else if (stg.from_mem) begin
      res_in.dac_code = to_dac(rd_data);
    end else begin
      res_in.dac_code = DAC_ZERO;
    end
  end

  afm_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stg.valid),
    .data_i  (res_in),
    .pop_i   (pop),
    .head_o  (res_out),
    .empty_o (empty),
    .count_o (q_count)
  );

  assign accepted_o   = res_out.accepted;
  assign dac_valid_o  = res_out.dac_valid;
  assign dac_code_o   = res_out.dac_code;
  assign underflow_o  = res_out.underflow;
  assign fifo_count_o = res_out.fifo_count;
  assign render_on_o  = res_out.render_on;

  a_beat_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> ##1 !empty)
    else $error("accepted beat did not reach the result queue");

  a_push_or_dac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(accepted_o && dac_valid_o))
    else $error("push and DAC issue in one beat");

  a_underflow_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && underflow_o |-> dac_valid_o && (dac_code_o == DAC_ZERO))
    else $error("underflow without mid-scale code");

  a_idle_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !dac_valid_o |-> (dac_code_o == '0) && !underflow_o)
    else $error("code present without DAC issue");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for audio_fifo_mono_dac_feeder: random and corner beats, with a scoreboard
// that tracks the sample ring, rate timer and render flag. Depends on afm_pkg and the block RTL.
module testbench;
  import afm_pkg::*;

  localparam logic [1:0] FUNC_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;

  class dac_feed_scoreboard;
    logic [SAMPLE_W-1:0] samples [FIFO_DEPTH];
    logic [PTR_W-1:0]    wr_ptr;
    logic [PTR_W-1:0]    rd_ptr;
    logic [PERIOD_W-1:0] rate_count;
    logic [PERIOD_W-1:0] period;
    bit                  rendering;
    res_t                due_results [$];
    int                  errors;
    int                  n_checked;

    function new();
      wr_ptr     = '0;
      rd_ptr     = '0;
      rate_count = '0;
      period     = PERIOD_RESET;
      rendering  = 1'b0;
      errors     = 0;
      n_checked  = 0;
    endfunction

    function logic [CODE_W-1:0] held();
      logic [PTR_W-1:0] diff;
      diff = wr_ptr - rd_ptr;
      return CODE_W'(diff);
    endfunction

    function void note_beat(logic [1:0] f, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                            bit mix, bit blk_end);
      res_t                 want;
      logic [SAMPLE_W-1:0]  raw;
      logic [SAMPLE_W:0]    sum;
      want = '0;
      case (f)
        FUNC_PUSH: begin
          if (PTR_W'(wr_ptr + 1'b1) != rd_ptr) begin
            sum = {l[SAMPLE_W-1], l} + {r[SAMPLE_W-1], r};
            samples[wr_ptr] = mix ? sum[SAMPLE_W:1] : l;
            wr_ptr++;
            want.accepted = 1'b1;
            if (blk_end) rendering = 1'b1;
          end
        end
        FUNC_TICK: begin
          if (rendering) begin
            if (rate_count >= period) begin
              rate_count = '0;
              raw = '0;
              if (wr_ptr != rd_ptr) begin
                raw = samples[rd_ptr];
                rd_ptr++;
              end else begin
                want.underflow = 1'b1;
              end
              raw = raw + 16'h8000;
              want.dac_valid = 1'b1;
              want.dac_code  = raw[SAMPLE_W-1:SAMPLE_W-CODE_W];
            end else begin
              rate_count++;
            end
          end
        end
        FUNC_STOP: rendering = 1'b0;
        default: ;
      endcase
      want.fifo_count = held();
      want.render_on  = rendering;
      due_results.push_back(want);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_field(string name, logic [CODE_W-1:0] got_v, logic [CODE_W-1:0] want_v);
      if (got_v !== want_v)
        report($sformatf("beat %0d %s got %0d expected %0d", n_checked, name, got_v, want_v));
    endtask

    task check_beat(res_t got);
      res_t want;
      n_checked++;
      if (due_results.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing due", n_checked));
        return;
      end
      want = due_results.pop_front();
      check_field("accepted", CODE_W'(got.accepted), CODE_W'(want.accepted));
      check_field("dac_valid", CODE_W'(got.dac_valid), CODE_W'(want.dac_valid));
      check_field("dac_code", got.dac_code, want.dac_code);
      check_field("underflow", CODE_W'(got.underflow), CODE_W'(want.underflow));
      check_field("fifo_count", got.fifo_count, want.fifo_count);
      check_field("render_on", CODE_W'(got.render_on), CODE_W'(want.render_on));
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [PERIOD_W-1:0]  cfg_wdata_i;
  logic                 push;
  logic                 full;
  logic [1:0]           func_i;
  logic [SAMPLE_W-1:0]  left_sample_i;
  logic [SAMPLE_W-1:0]  right_sample_i;
  logic                 mix_two_i;
  logic                 block_end_i;
  logic                 empty;
  logic                 pop;
  logic                 accepted_o;
  logic                 dac_valid_o;
  logic [CODE_W-1:0]    dac_code_o;
  logic                 underflow_o;
  logic [CODE_W-1:0]    fifo_count_o;
  logic                 render_on_o;

  dac_feed_scoreboard feed_sb = new();
  int                 n_cycles = 0;
  bit                 tx_calm = 1'b0;
  bit                 rx_calm = 1'b0;

  audio_fifo_mono_dac_feeder u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .mix_two_i      (mix_two_i),
    .block_end_i    (block_end_i),
    .empty          (empty),
    .pop            (pop),
    .accepted_o     (accepted_o),
    .dac_valid_o    (dac_valid_o),
    .dac_code_o     (dac_code_o),
    .underflow_o    (underflow_o),
    .fifo_count_o   (fifo_count_o),
    .render_on_o    (render_on_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(3, 1);
    if (p < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 20);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // offer one beat, hold it until taken, then maybe leave a gap
  task automatic send_beat(logic [1:0] f, logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r,
                           bit mix, bit blk_end);
    int gap;
    push           <= 1'b1;
    func_i         <= f;
    left_sample_i  <= l;
    right_sample_i <= r;
    mix_two_i      <= mix;
    block_end_i    <= blk_end;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    feed_sb.note_beat(f, l, r, mix, blk_end);
    if ($urandom_range(99) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random(int w_push, int w_tick, int w_stop, int be_pct);
    int         p;
    logic [1:0] f;
    p = $urandom_range(99);
    if (p < w_push) f = FUNC_PUSH;
    else if (p < w_push + w_tick) f = FUNC_TICK;
    else if (p < w_push + w_tick + w_stop) f = FUNC_STOP;
    else f = FUNC_SPARE;
    send_beat(f, rand_sample(), rand_sample(), 1'($urandom_range(1)),
              $urandom_range(99) < be_pct);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (feed_sb.due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    feed_sb.period  = v;
  endtask

  initial begin : drain
    res_t got;
    int   stall_left;
    int   hold_mark;
    stall_left = 0;
    hold_mark  = 600;
    pop <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = '{accepted: accepted_o, dac_valid: dac_valid_o, dac_code: dac_code_o,
                underflow: underflow_o, fifo_count: fifo_count_o, render_on: render_on_o};
        feed_sb.check_beat(got);
      end
      if (feed_sb.n_checked >= hold_mark) begin
        stall_left = 400;
        hold_mark += 700;
      end
      if ($urandom_range(199) == 0) rx_calm = !rx_calm;
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall_left = rx_calm ? 0 : pick_gap();
      end
    end
  end

  initial begin : stimulus
    int fill_extra;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    push           <= 1'b0;
    func_i         <= FUNC_PUSH;
    left_sample_i  <= '0;
    right_sample_i <= '0;
    mix_two_i      <= 1'b0;
    block_end_i    <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_period(20'd1);
    send_beat(FUNC_SPARE, 16'h1234, 16'hBEEF, 1'b1, 1'b1);
    send_beat(FUNC_TICK, rand_sample(), rand_sample(), 1'b1, 1'b1);
    send_beat(FUNC_STOP, rand_sample(), rand_sample(), 1'b0, 1'b1);
    send_beat(FUNC_PUSH, 16'h8000, 16'h7FFF, 1'b0, 1'b0);
    send_beat(FUNC_PUSH, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
    send_beat(FUNC_PUSH, 16'h8000, 16'h8000, 1'b1, 1'b0);
    send_beat(FUNC_PUSH, 16'h7FFF, 16'h7FFF, 1'b1, 1'b0);
    send_beat(FUNC_PUSH, 16'hFFFF, 16'h0000, 1'b1, 1'b0);
    send_beat(FUNC_PUSH, 16'h7FFF, 16'h8000, 1'b1, 1'b0);
    send_beat(FUNC_PUSH, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
    // drains the seven samples, then one underflow
    repeat (16) send_beat(FUNC_TICK, rand_sample(), rand_sample(), 1'b0, 1'b0);
    send_beat(FUNC_STOP, rand_sample(), rand_sample(), 1'b1, 1'b0);
    send_beat(FUNC_TICK, rand_sample(), rand_sample(), 1'b0, 1'b1);

    wait_drained();
    write_period(PERIOD_W'($urandom_range(4)));
    repeat (20) send_random(45, 45, 5, 15);

    // fill the ring with rendering off, then keep hammering it while full
    wait_drained();
    write_period('0);
    send_beat(FUNC_STOP, rand_sample(), rand_sample(), 1'b0, 1'b0);
    tx_calm    = 1'b1;
    fill_extra = 0;
    while (fill_extra < 20) begin
      send_random(97, 2, 1, (feed_sb.held() > 1015) ? 50 : 0);
      if (feed_sb.held() == 1023) fill_extra++;
    end
    tx_calm = 1'b0;

    wait_drained();
    write_period('0);
    repeat (20) send_random(30, 60, 5, 30);

    wait_drained();
    write_period('1);
    send_beat(FUNC_PUSH, rand_sample(), rand_sample(), 1'($urandom_range(1)), 1'b1);
    repeat (15) send_random(25, 75, 0, 50);

    // period now below the running count
    wait_drained();
    write_period(PERIOD_W'($urandom_range(3, 1)));
    repeat (15) send_random(40, 50, 5, 20);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (feed_sb.errors == 0 && feed_sb.due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/afm_pkg.sv
hdl/afm_front.sv
hdl/afm_resq.sv
hdl/audio_fifo_mono_dac_feeder.sv
tb/testbench.sv
